>>> rtl/srt_pkg.sv
// srt_pkg: shared types, constants and the control store for the semiprime test unit.
// Used by srt_useq and semiprime_range_test_unit; depends on nothing.
`timescale 1ns / 1ps

package srt_pkg;

  localparam int VAL_W    = 16;  // candidate, limits, echoed value
  localparam int SF_W     = 8;   // small factor field
  localparam int LF_W     = 15;  // large factor field
  localparam int CFG_IDX_W = 2;
  localparam int PC_W     = 4;
  localparam int UCODE_N  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 2'd1;

  localparam logic [VAL_W-1:0] LOWER_RESET = 16'd1;
  localparam logic [VAL_W-1:0] UPPER_RESET = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_NEXT,
    OP_SETQ,
    OP_SETOK,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_N_LT4,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_OUT_BUSY
  } ucond_t;

  typedef struct packed {
    uop_t            op;
    ucond_t          cond;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic no_in;
    logic n_lt4;
    logic sq_gt;
    logic div_busy;
    logic rem_zero;
    logic out_busy;
  } useq_stat_t;

  // step labels
  localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] S_LOOP1  = 4'd2;
  localparam logic [PC_W-1:0] S_WAIT1  = 4'd4;
  localparam logic [PC_W-1:0] S_FOUND  = 4'd7;
  localparam logic [PC_W-1:0] S_LOOP2  = 4'd8;
  localparam logic [PC_W-1:0] S_WAIT2  = 4'd10;
  localparam logic [PC_W-1:0] S_PASS   = 4'd13;
  localparam logic [PC_W-1:0] S_WAITO  = 4'd14;

  // smallest divisor search, then cofactor primality check from that divisor up
  localparam ucw_t UCODE [0:UCODE_N-1] = '{
    '{OP_LOAD,  C_NO_IN,    S_IDLE },  // 0  wait for item
    '{OP_NOP,   C_N_LT4,    S_WAITO},  // 1
    '{OP_NOP,   C_SQ_GT,    S_WAITO},  // 2  n is prime
    '{OP_DIV,   C_NEVER,    S_IDLE },  // 3
    '{OP_NOP,   C_DIV_BUSY, S_WAIT1},  // 4
    '{OP_NOP,   C_REM_ZERO, S_FOUND},  // 5
    '{OP_NEXT,  C_ALWAYS,   S_LOOP1},  // 6
    '{OP_SETQ,  C_NEVER,    S_IDLE },  // 7  p = d, q = n / d
    '{OP_NOP,   C_SQ_GT,    S_PASS },  // 8  q is prime
    '{OP_DIV,   C_NEVER,    S_IDLE },  // 9
    '{OP_NOP,   C_DIV_BUSY, S_WAIT2},  // 10
    '{OP_NOP,   C_REM_ZERO, S_WAITO},  // 11 q composite
    '{OP_NEXT,  C_ALWAYS,   S_LOOP2},  // 12
    '{OP_SETOK, C_NEVER,    S_IDLE },  // 13
    '{OP_NOP,   C_OUT_BUSY, S_WAITO},  // 14
    '{OP_EMIT,  C_ALWAYS,   S_IDLE }   // 15
  };

endpackage

>>> rtl/srt_div.sv
// srt_div: restoring shift-subtract divider, one quotient bit per cycle.
// Used by semiprime_range_test_unit; no package dependencies.
`timescale 1ns / 1ps

module srt_div #(
  parameter int NB = 16,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NB-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NB-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(NB + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] acc_r;
  logic [NB-1:0] quo_r;
  logic [DW-1:0] dvs_r;

  logic [DW:0]   sh;
  logic [DW:0]   diff;

  assign sh   = {acc_r, quo_r[NB-1]};
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        acc_r <= diff[DW-1:0];
        quo_r <= {quo_r[NB-2:0], 1'b1};
      end else begin
        acc_r <= sh[DW-1:0];
        quo_r <= {quo_r[NB-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = acc_r;

endmodule

>>> rtl/srt_useq.sv
// srt_useq: microsequencer with step counter, control store lookup and conditional jumps.
// Depends on srt_pkg for the control word, status struct and program.
`timescale 1ns / 1ps

module srt_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  srt_pkg::useq_stat_t stat,
  output srt_pkg::ucw_t       ucw
);

  import srt_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            taken;

  assign ucw = UCODE[pc_r];

  always_comb begin
    unique case (ucw.cond)
      C_NEVER:    taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_IN:    taken = stat.no_in;
      C_N_LT4:    taken = stat.n_lt4;
      C_SQ_GT:    taken = stat.sq_gt;
      C_DIV_BUSY: taken = stat.div_busy;
      C_REM_ZERO: taken = stat.rem_zero;
      C_OUT_BUSY: taken = stat.out_busy;
    endcase
    pc_nxt = taken ? ucw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/semiprime_range_test_unit.sv
// semiprime_range_test_unit: top level, datapath registers, limits and output register.
// Depends on srt_pkg, srt_div and srt_useq.
`timescale 1ns / 1ps

// Tests one candidate per item for being a semiprime p*q (p <= q, both prime)
// inside [lower_limit, upper_limit] and returns p and q, or zeros. The smallest
// divisor is found by trial division from 2 while d*d <= n, then the cofactor is
// checked for divisors from p up. Every trial divisor takes one run of the
// shared shift-subtract divider, which yields one quotient bit per cycle
// (NB = min(VALUE_BITS,16)). Candidates 0..3 skip the search, multiples of 4
// are settled by divisor 2 alone, and a 16-bit prime is the longest case. One
// item is in work at a time; the next one is taken as soon as the result moves
// into the output register.
module semiprime_range_test_unit #(
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [srt_pkg::VAL_W-1:0]             in_candidate,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_is_semiprime,
  output logic [srt_pkg::SF_W-1:0]              out_small_factor,
  output logic [srt_pkg::LF_W-1:0]              out_large_factor,
  output logic [srt_pkg::VAL_W-1:0]             out_tested_value,
  input  logic                                  cfg_we,
  input  logic [srt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [srt_pkg::VAL_W-1:0]             cfg_wdata
);

  import srt_pkg::*;

  localparam int NB  = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int DW  = (NB + 1) / 2 + 1;
  localparam int SQW = 2 * DW;

  ucw_t       ucw;
  useq_stat_t stat;

  logic [VAL_W-1:0] lower_r;
  logic [VAL_W-1:0] upper_r;

  logic [VAL_W-1:0] cand_r;
  logic [NB-1:0]    n_r;
  logic [NB-1:0]    num_r;
  logic [DW-1:0]    d_r;
  logic [SQW-1:0]   sq_r;
  logic [DW-1:0]    p_r;
  logic [NB-1:0]    q_r;
  logic             ok_r;

  logic             out_valid_r;
  logic             out_is_semiprime_r;
  logic [SF_W-1:0]  out_small_factor_r;
  logic [LF_W-1:0]  out_large_factor_r;
  logic [VAL_W-1:0] out_tested_value_r;

  logic             div_start;
  logic             div_busy;
  logic [NB-1:0]    div_quot;
  logic [DW-1:0]    div_rem;

  logic             in_range;
  logic             pass;
  logic [31:0]      p_ext;
  logic [31:0]      q_ext;
  logic             emit;

  srt_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ucw   (ucw)
  );

  srt_div #(
    .NB (NB),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_ready  = (ucw.op == OP_LOAD);
  assign div_start = (ucw.op == OP_DIV);
  assign emit      = (ucw.op == OP_EMIT);

  assign stat.no_in    = !in_valid;
  assign stat.n_lt4    = (n_r < NB'(4));
  assign stat.sq_gt    = (sq_r > SQW'(num_r));
  assign stat.div_busy = div_busy;
  assign stat.rem_zero = (div_rem == '0);
  assign stat.out_busy = out_valid_r && !out_ready;

  // limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWER_LIMIT: lower_r <= cfg_wdata;
        CFG_UPPER_LIMIT: upper_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (ucw.op)
      OP_LOAD: begin
        if (in_valid) begin
          cand_r <= in_candidate;
          n_r    <= in_candidate[NB-1:0];
          num_r  <= in_candidate[NB-1:0];
          d_r    <= DW'(2);
          sq_r   <= SQW'(4);
          ok_r   <= 1'b0;
        end
      end
      OP_NEXT: begin
        d_r  <= d_r + 1'b1;
        sq_r <= sq_r + SQW'({d_r, 1'b1});
      end
      OP_SETQ: begin
        p_r   <= d_r;
        q_r   <= div_quot;
        num_r <= div_quot;
      end
      OP_SETOK: ok_r <= 1'b1;
      OP_NOP, OP_DIV, OP_EMIT: ;
    endcase
  end

  assign in_range = (VAL_W'(n_r) >= lower_r) && (VAL_W'(n_r) <= upper_r);
  assign pass     = ok_r && in_range;
  assign p_ext    = 32'(p_r);
  assign q_ext    = 32'(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_is_semiprime_r <= pass;
      out_small_factor_r <= pass ? p_ext[SF_W-1:0] : '0;
      out_large_factor_r <= pass ? q_ext[LF_W-1:0] : '0;
      out_tested_value_r <= cand_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_semiprime = out_is_semiprime_r;
  assign out_small_factor = out_small_factor_r;
  assign out_large_factor = out_large_factor_r;
  assign out_tested_value = out_tested_value_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer stayed idle after taking an item");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_pass_has_factors: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_semiprime |-> out_small_factor != '0 && out_large_factor != '0)
    else $error("semiprime reported without factors");

  a_fail_zero_factors: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_semiprime |-> out_small_factor == '0 && out_large_factor == '0)
    else $error("factors nonzero on failed test");

endmodule

>>> test/tb_semiprime_range_test_unit.sv
`timescale 1ns / 1ps
// tb_semiprime_range_test_unit: self-checking bench for semiprime_range_test_unit.
// Feeds candidates under several limit settings with random idling and back-pressure, and
// checks each result against a trial-division predictor. Depends on srt_pkg and the RTL.

module tb_semiprime_range_test_unit;
  import srt_pkg::*;

  localparam int CYCLE_LIMIT   = 16_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic            semi;
    logic [SF_W-1:0] pf;
    logic [LF_W-1:0] qf;
    logic [VAL_W-1:0] echo;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     in_candidate = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_is_semiprime;
  logic [SF_W-1:0]      out_small_factor;
  logic [LF_W-1:0]      out_large_factor;
  logic [VAL_W-1:0]     out_tested_value;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_wdata = '0;

  logic [VAL_W-1:0] lim_lo = LOWER_RESET;
  logic [VAL_W-1:0] lim_hi = UPPER_RESET;
  verdict_t         pending_verdicts[$];
  int               mismatch_count = 0;
  int unsigned      cycle_count = 0;
  bit               src_jitter = 1'b0;
  bit               sink_jitter = 1'b0;
  bit               hold_request = 1'b0;

  semiprime_range_test_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_semiprime (out_is_semiprime),
    .out_small_factor (out_small_factor),
    .out_large_factor (out_large_factor),
    .out_tested_value (out_tested_value),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_semiprime_range_test_unit NOT OK");
      $finish;
    end
  end

  function automatic int unsigned first_divisor(int unsigned n, int unsigned from);
    for (int unsigned d = from; d * d <= n; d++)
      if (n % d == 0) return d;
    return 0;
  endfunction

  // true when n = p * q with p <= q both prime
  function automatic bit semiprime_split(int unsigned n, output int unsigned p,
                                         output int unsigned q);
    p = 0;
    q = 0;
    if (n < 4) return 1'b0;
    p = first_divisor(n, 2);
    if (p == 0) return 1'b0;
    q = n / p;
    return first_divisor(q, p) == 0;
  endfunction

  function automatic verdict_t judge_candidate(logic [VAL_W-1:0] cand);
    int unsigned p, q;
    verdict_t v;
    v.semi = semiprime_split(cand, p, q) && cand >= lim_lo && cand <= lim_hi;
    v.pf = v.semi ? p[SF_W-1:0] : '0;
    v.qf = v.semi ? q[LF_W-1:0] : '0;
    v.echo = cand;
    return v;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 12);
    return $urandom_range(40, 150);
  endfunction

  // mostly small values to keep trial division short, a few full-width ones
  function automatic logic [VAL_W-1:0] pick_candidate();
    int r;
    int unsigned c, p, q;
    r = $urandom_range(0, 99);
    if (r < 55) return VAL_W'($urandom_range(0, 1023));
    if (r < 72) return VAL_W'($urandom_range(1024, 4095));
    if (r < 87) begin
      for (int k = 0; k < 64; k++) begin
        c = (r < 84) ? $urandom_range(4, 4095) : $urandom_range(4, 65535);
        if (semiprime_split(c, p, q)) break;
      end
      return VAL_W'(c);
    end
    if (r < 96) return VAL_W'($urandom_range(0, 65535));
    if (r < 98) return VAL_W'(1) << $urandom_range(0, VAL_W - 1);
    return VAL_W'(16'hFFFF - $urandom_range(0, 40));
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && sink_jitter && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result for %0d", $time, out_tested_value);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if ({out_is_semiprime, out_small_factor, out_large_factor, out_tested_value}
            !== want) begin
          $display("%0t: mismatch expected semi=%0d p=%0d q=%0d value=%0d", $time,
                   want.semi, want.pf, want.qf, want.echo);
          $display("%0t:            actual semi=%0d p=%0d q=%0d value=%0d", $time,
                   out_is_semiprime, out_small_factor, out_large_factor,
                   out_tested_value);
          mismatch_count++;
        end
      end
    end
  end

  // returns at the accepting edge with valid still high
  task automatic send_candidate(input logic [VAL_W-1:0] cand);
    int gap;
    gap = (src_jitter && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_candidate <= VAL_W'($urandom());
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_candidate <= cand;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(judge_candidate(cand));
  endtask

  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOWER_LIMIT: lim_lo = data;
      CFG_UPPER_LIMIT: lim_hi = data;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [VAL_W-1:0] lo, hi);
    wait_all_results();
    write_reg(CFG_LOWER_LIMIT, lo);
    write_reg(CFG_UPPER_LIMIT, hi);
  endtask

  task automatic set_idling(input bit src, sink);
    @(posedge clk);
    src_jitter = src;
    sink_jitter = sink;
  endtask

  task automatic probe_limits(input logic [VAL_W-1:0] lo, hi, a, b);
    set_limits(lo, hi);
    send_candidate(a);
    send_candidate(b);
  endtask

  // zero, one, primes, prime squares, three-factor products, field extremes
  task automatic test_corner_candidates();
    logic [VAL_W-1:0] picks [15] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd8, 16'd9,
                                    16'd30, 16'h5555, 16'hAAAA, 16'hFFFF, 16'd65498,
                                    16'd63001, 16'd64507, 16'd65521};
    set_idling(1'b1, 1'b1);
    foreach (picks[i]) send_candidate(picks[i]);
  endtask

  // single-value window, zero lower bound, inverted bounds, unused register indexes
  task automatic test_limit_settings();
    probe_limits(16'd15, 16'd15, 16'd15, 16'd14);
    probe_limits(16'd0, 16'd100, 16'd4, 16'd106);
    probe_limits(16'hFFFF, 16'hFFFF, 16'd65498, 16'hFFFF);
    probe_limits(16'hFFFF, 16'd1, 16'd6, 16'd65498);
    probe_limits(16'd1000, 16'd10, 16'd9, 16'd1003);
    probe_limits(16'd63001, 16'd64507, 16'd63001, 16'd64507);
    set_limits(LOWER_RESET, UPPER_RESET);
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h0010);
    send_candidate(16'd9);
    send_candidate(16'd65498);
  endtask

  // long receiver hold-off fills the block, then a source pause, then a tight burst
  task automatic test_flow_control();
    set_idling(1'b0, 1'b0);
    wait_all_results();
    @(posedge clk);
    hold_request = 1'b1;
    repeat (30) send_candidate(VAL_W'(4 * $urandom_range(1, 16383)));
    wait_all_results();
    repeat (20) send_candidate(pick_candidate());
  endtask

  task automatic test_random_phases();
    logic [VAL_W-1:0] lo, hi;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          lo = LOWER_RESET;
          hi = UPPER_RESET;
        end
        1: begin
          lo = VAL_W'($urandom_range(0, 600));
          hi = VAL_W'($urandom_range(2000, 65535));
        end
        2: begin
          lo = VAL_W'($urandom());
          hi = VAL_W'($urandom());
        end
        default: begin
          lo = VAL_W'($urandom_range(0, 3));
          hi = VAL_W'($urandom_range(30000, 65535));
        end
      endcase
      set_limits(lo, hi);
      if (ph == 3) begin
        write_reg(CFG_SPARE_2, VAL_W'($urandom()));
        write_reg(CFG_SPARE_3, VAL_W'($urandom()));
      end
      set_idling(ph % 4 != 1 && ph != 5, ph % 4 != 2 && ph != 5);
      repeat (PHASE_ITEMS) send_candidate(pick_candidate());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_corner_candidates();
    test_limit_settings();
    test_flow_control();
    test_random_phases();
    wait_all_results();
    if (mismatch_count == 0 && pending_verdicts.size() == 0)
      $display("tb_semiprime_range_test_unit OK");
    else
      $display("tb_semiprime_range_test_unit NOT OK");
    $finish;
  end

endmodule
